[rtl/core/positional_array_list_assert.svh]
// Assertion macros for the positional array list RTL, used by pal_ctrl.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Check a property on every edge outside reset.
`define PAL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PAL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pal_pkg.sv]
// Shared types and constants for the positional array list.
// No dependencies.
package pal_pkg;

	localparam int CAPACITY = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
	localparam int KEY_W    = 32;
	localparam int DATA_W   = 64;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_REMOVE    = 3'd2,
		CMD_OVERWRITE = 3'd3,
		CMD_SEARCH    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_NOKEY  = 2'd3
	} status_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             ovr;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] count;
	} cell_ctl_t;

endpackage

[rtl/core/pal_cell.sv]
// One slot of the list: holds a key and data word, shifts with its neighbors.
// Depends on pal_pkg.
module pal_cell import pal_pkg::*; (
	input  logic              clk,
	input  logic [CMP_W-1:0]  slot,
	input  cell_ctl_t         ctl,
	input  logic [KEY_W-1:0]  new_key,
	input  logic [DATA_W-1:0] new_data,
	input  logic [KEY_W-1:0]  left_key,
	input  logic [DATA_W-1:0] left_data,
	input  logic [KEY_W-1:0]  right_key,
	input  logic [DATA_W-1:0] right_data,
	output logic [KEY_W-1:0]  key,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              take_new;
	logic              take_left;
	logic              take_right;

	// Pick where this slot loads from
	always_comb begin
		take_new   = (ctl.ins || ctl.ovr) && (slot == ctl.pos);
		take_left  = ctl.ins && (slot > ctl.pos) && (slot <= ctl.count);
		take_right = ctl.rem && (slot >= ctl.pos) && ((slot + 1'b1) < ctl.count);
	end

	// Load the slot
	always_ff @(posedge clk) begin
		if (take_new) begin
			key_q  <= new_key;
			data_q <= new_data;
		end else if (take_left) begin
			key_q  <= left_key;
			data_q <= left_data;
		end else if (take_right) begin
			key_q  <= right_key;
			data_q <= right_data;
		end
	end

	// Flag a key hit in an occupied slot
	assign match = (slot < ctl.count) && (key_q == new_key);
	assign key   = key_q;
	assign data  = data_q;

endmodule

[rtl/core/pal_ctrl.sv]
// Command decode, entry count and result register for the positional list.
// Depends on pal_pkg and positional_array_list_assert.svh.
`include "positional_array_list_assert.svh"
module pal_ctrl import pal_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cmd_t       cmd,
	input  logic [3:0] pos,
	input  logic       match_any,
	output cell_ctl_t  ctl,
	output logic       out_valid,
	input  logic       out_ready,
	output status_t    status,
	output logic [3:0] entry_count
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             out_valid_q;
	status_t          status_q;
	logic [3:0]       entry_count_q;
	status_t          status_c;
	logic             in_fire;
	logic             full;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             ins_c;
	logic             rem_c;
	logic             ovr_c;
	logic [CMP_W-1:0] tpos_c;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign pos_ext  = CMP_W'(pos);
	assign cnt_ext  = CMP_W'(count_q);
	assign full     = (count_q == CNT_W'(CAPACITY));

	// Decode the command against the current count
	always_comb begin
		status_c   = ST_DONE;
		ins_c      = 1'b0;
		rem_c      = 1'b0;
		ovr_c      = 1'b0;
		tpos_c     = pos_ext;
		count_next = count_q;
		unique case (cmd)
			CMD_APPEND: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ins_c      = 1'b1;
					tpos_c     = cnt_ext;
					count_next = count_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status_c = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					status_c = ST_BADPOS;
				end else begin
					ins_c      = 1'b1;
					count_next = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status_c = ST_BADPOS;
				end else begin
					rem_c      = 1'b1;
					count_next = count_q - 1'b1;
				end
			end
			CMD_OVERWRITE: begin
				if (pos_ext >= cnt_ext) status_c = ST_BADPOS;
				else ovr_c = 1'b1;
			end
			CMD_SEARCH: begin
				status_c = match_any ? ST_DONE : ST_NOKEY;
			end
			default: begin
				status_c = ST_BADPOS;
			end
		endcase
	end

	// Drive the cell row
	always_comb begin
		ctl.ins   = in_fire && ins_c;
		ctl.rem   = in_fire && rem_c;
		ctl.ovr   = in_fire && ovr_c;
		ctl.pos   = tpos_c;
		ctl.count = cnt_ext;
	end

	// Advance the count and hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q      <= status_c;
			entry_count_q <= 4'(CMP_W'(count_next));
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	`PAL_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`PAL_ASSERT(a_count_idle, !in_fire |=> $stable(count_q), "count moved without a command")
	`PAL_ASSERT(a_full_count, out_valid_q && status_q == ST_FULL |-> full,
		"full status with room left")

endmodule

[rtl/core/positional_array_list.sv]
// Top level of the positional array list: controller plus a row of slot cells.
// Depends on pal_pkg, pal_ctrl and pal_cell.

// Bounded ordered list of CAPACITY key/data entries. Each input word carries one
// command (append, insert, remove, overwrite, search) and yields one result word
// with a status and the entry count after the command. The row of CAPACITY cells
// shifts up or down and compares keys in parallel, so a new word is accepted every
// cycle while the one-deep result register is empty or being taken, and the
// registered result appears in the cycle after acceptance. Slot contents are not
// cleared at reset; only occupied slots are ever read.
module positional_array_list import pal_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[2:0], position[6:3], entry_key[38:7], entry_data[102:39], zero[103]
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], entry_count[5:2], zero[7:6]
	output logic [7:0]   m_tdata
);

	cell_ctl_t         ctl;
	logic [KEY_W-1:0]  key_w  [CAPACITY];
	logic [DATA_W-1:0] data_w [CAPACITY];
	logic [CAPACITY-1:0] match_w;
	logic [KEY_W-1:0]  new_key;
	logic [DATA_W-1:0] new_data;
	status_t           status;
	logic [3:0]        entry_count;

	assign new_key  = s_tdata[38:7];
	assign new_data = s_tdata[102:39];

	// Command decode and result register
	pal_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (cmd_t'(s_tdata[2:0])),
		.pos         (s_tdata[6:3]),
		.match_any   (|match_w),
		.ctl         (ctl),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (status),
		.entry_count (entry_count)
	);

	// Row of slot cells, each wired to its neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_W-1:0]  lk;
		logic [DATA_W-1:0] ld;
		logic [KEY_W-1:0]  rk;
		logic [DATA_W-1:0] rd;

		if (g == 0) begin : g_first
			assign lk = '0;
			assign ld = '0;
		end else begin : g_mid_l
			assign lk = key_w[g-1];
			assign ld = data_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign rk = '0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rk = key_w[g+1];
			assign rd = data_w[g+1];
		end

		pal_cell u_cell (
			.clk        (clk),
			.slot       (CMP_W'(g)),
			.ctl        (ctl),
			.new_key    (new_key),
			.new_data   (new_data),
			.left_key   (lk),
			.left_data  (ld),
			.right_key  (rk),
			.right_data (rd),
			.key        (key_w[g]),
			.data       (data_w[g]),
			.match      (match_w[g])
		);
	end

	assign m_tdata = {2'b00, entry_count, status};

endmodule

[tb/sv/tb_positional_array_list.sv]
// Self-checking testbench for the positional array list: random and directed command
// words go through the stream slave port, and each result word is checked against a list kept here.
// Depends on pal_pkg and positional_array_list.
`timescale 1ns / 1ps

module tb_positional_array_list;
	import pal_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RESET_CYCLES = 11;
	localparam int NUM_PHASES   = 4;
	localparam int RANDOM_WORDS = 331;
	localparam int SETTLE_CYCLES = 20;

	// Command codes the block does not define
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [3:0] POS_MAX       = 4'hF;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

	typedef struct {
		logic [2:0]              command;
		logic [3:0]              position;
		logic signed [KEY_W-1:0] entry_key;
		logic [DATA_W-1:0]       entry_data;
	} list_cmd_t;

	typedef struct {
		status_t    status;
		logic [3:0] entry_count;
	} list_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;

	// Shadow copy of the list contents
	logic signed [KEY_W-1:0] list_keys [CAPACITY];
	logic [DATA_W-1:0]       list_data [CAPACITY];
	int                      list_count = 0;

	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  word_taken = 1'b0;
	int  cycle_count = 0;
	int  error_count = 0;

	list_cmd_t    taken_cmd;
	list_result_t predicted;
	list_result_t oldest;

	int idle_by_phase  [NUM_PHASES] = '{0, 63, 0, 30};
	int stall_by_phase [NUM_PHASES] = '{0, 0, 63, 30};

	positional_array_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one command to the shadow list and work out its result word
	task automatic apply_command(input list_cmd_t c, output list_result_t r);
		int i;
		r.status = ST_DONE;
		case (c.command)
			CMD_APPEND: begin
				if (list_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_keys[list_count] = c.entry_key;
					list_data[list_count] = c.entry_data;
					list_count++;
				end
			end
			CMD_INSERT: begin
				if (list_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (int'(c.position) > list_count) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = list_count; i > int'(c.position); i--) begin
						list_keys[i] = list_keys[i-1];
						list_data[i] = list_data[i-1];
					end
					list_keys[c.position] = c.entry_key;
					list_data[c.position] = c.entry_data;
					list_count++;
				end
			end
			CMD_REMOVE: begin
				if (int'(c.position) >= list_count) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = int'(c.position); i + 1 < list_count; i++) begin
						list_keys[i] = list_keys[i+1];
						list_data[i] = list_data[i+1];
					end
					list_count--;
				end
			end
			CMD_OVERWRITE: begin
				if (int'(c.position) >= list_count) begin
					r.status = ST_BADPOS;
				end else begin
					list_keys[c.position] = c.entry_key;
					list_data[c.position] = c.entry_data;
				end
			end
			CMD_SEARCH: begin
				r.status = ST_NOKEY;
				for (i = 0; i < list_count; i++) begin
					if (list_keys[i] == c.entry_key) begin
						r.status = ST_DONE;
						break;
					end
				end
			end
			default: begin
				r.status = ST_BADPOS;
			end
		endcase
		r.entry_count = 4'(list_count);
	endtask

	task automatic queue_cmd(input logic [2:0] cmd, input logic [3:0] pos,
			input logic signed [KEY_W-1:0] key, input logic [DATA_W-1:0] data);
		list_cmd_t c;
		c.command    = cmd;
		c.position   = pos;
		c.entry_key  = key;
		c.entry_data = data;
		pending_cmds.push_back(c);
	endtask

	// Random command, weighted so the list fills and drains and searches often hit
	task automatic queue_random_cmd();
		int pick;
		logic [2:0] cmd;
		logic [3:0] pos;
		logic signed [KEY_W-1:0] key;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			cmd = CMD_APPEND;
		else if (pick < 40)
			cmd = CMD_INSERT;
		else if (pick < 70)
			cmd = CMD_REMOVE;
		else if (pick < 80)
			cmd = CMD_OVERWRITE;
		else if (pick < 95)
			cmd = CMD_SEARCH;
		else
			cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if ($urandom_range(0, 99) < 85)
			pos = 4'($urandom_range(0, CAPACITY + 1));
		else
			pos = 4'($urandom_range(0, POS_MAX));
		pick = $urandom_range(0, 99);
		if (pick < 60)
			key = int'($urandom_range(0, 15)) - 8;
		else if (pick < 65)
			key = (pick < 63) ? KEY_MIN : KEY_MAX;
		else
			key = $urandom;
		queue_cmd(cmd, pos, key, {$urandom, $urandom});
	endtask

	// Corner cases: empty list, full list, positions at and past the end, bad codes
	task automatic queue_directed_cmds();
		int i;
		queue_cmd(CMD_REMOVE, 4'd0, 32'sd0, '0);
		queue_cmd(CMD_OVERWRITE, 4'd0, 32'sd1, DATA_ONES);
		queue_cmd(CMD_SEARCH, 4'd0, 32'sd0, '0);
		queue_cmd(CMD_INSERT, 4'd1, 32'sd2, '0);
		queue_cmd(CMD_INSERT, 4'd0, KEY_MIN, '0);
		queue_cmd(CMD_APPEND, POS_MAX, KEY_MAX, DATA_ONES);
		queue_cmd(CMD_INSERT, 4'd2, -32'sd1, 64'h0123_4567_89AB_CDEF);
		queue_cmd(CMD_INSERT, 4'd1, 32'sd0, 64'hFEDC_BA98_7654_3210);
		for (i = 4; i < CAPACITY; i++)
			queue_cmd(CMD_APPEND, 4'(i), i, {$urandom, $urandom});
		queue_cmd(CMD_APPEND, 4'd0, 32'sd99, DATA_ONES);
		queue_cmd(CMD_INSERT, POS_MAX, 32'sd98, DATA_ONES);
		queue_cmd(CMD_SEARCH, POS_MAX, KEY_MIN, '0);
		queue_cmd(CMD_SEARCH, 4'd3, 32'sd12345, DATA_ONES);
		queue_cmd(CMD_OVERWRITE, 4'(CAPACITY - 1), 32'sd77, DATA_ONES);
		queue_cmd(CMD_OVERWRITE, 4'(CAPACITY), 32'sd78, '0);
		queue_cmd(CMD_REMOVE, POS_MAX, 32'sd0, '0);
		queue_cmd(CMD_REMOVE, 4'(CAPACITY - 1), 32'sd0, DATA_ONES);
		queue_cmd(CMD_REMOVE, 4'd0, KEY_MAX, '0);
		queue_cmd(CMD_UNUSED_LO, 4'd0, 32'sd0, '0);
		queue_cmd(CMD_UNUSED_LO + 3'd1, POS_MAX, KEY_MIN, DATA_ONES);
		queue_cmd(CMD_UNUSED_HI, 4'd1, KEY_MAX, DATA_ONES);
		queue_cmd(CMD_SEARCH, 4'd0, KEY_MAX, '0);
	endtask

	// Drive the slave side and the receiver ready on the falling edge
	always @(negedge clk) begin
		if (!(s_tvalid && !word_taken)) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {1'b0, pending_cmds[0].entry_data, pending_cmds[0].entry_key,
					pending_cmds[0].position, pending_cmds[0].command};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		word_taken = 1'b0;
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Sample both handshakes on the rising edge: predict taken words, check result words
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			if (s_tvalid && s_tready) begin
				taken_cmd = pending_cmds.pop_front();
				apply_command(taken_cmd, predicted);
				expected_results.push_back(predicted);
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: status %0d, entry_count %0d",
						m_tdata[1:0], m_tdata[5:2]);
					error_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (m_tdata[1:0] != oldest.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							oldest.status, m_tdata[1:0]);
						error_count++;
					end
					if (m_tdata[5:2] != oldest.entry_count) begin
						$error("entry_count mismatch: expected %0d, actual %0d",
							oldest.entry_count, m_tdata[5:2]);
						error_count++;
					end
				end
			end
		end
	end

	// Reset once, then run the phases; hold the sender between phases until all results are in
	initial begin
		int ph;
		int n;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct  = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			if (ph == 0)
				queue_directed_cmds();
			for (n = 0; n < RANDOM_WORDS; n++)
				queue_random_cmd();
			while (pending_cmds.size() != 0 || expected_results.size() != 0)
				@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
